>>> src/bsa_pkg.sv
package bsa_pkg;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Pool size after reset.
  localparam logic [8:0] POOL_SIZE_RST = 9'd256;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  // Outcome of the lowest-free-slot search.
  typedef struct packed {
    logic       found;
    logic [7:0] slot;
  } find_res_t;

endpackage

>>> src/bsa_ifs.sv
// Request channel: one allocate or free request per beat.
interface bsa_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] slot_index;

  modport source (output valid, mode, slot_index, input ready);
  modport sink   (input valid, mode, slot_index, output ready);
endinterface

// Result channel: one result per request.
interface bsa_rsp_if
  import bsa_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] granted_slot;
  status_t    status;
  logic [8:0] free_slots;

  modport source (output valid, granted_slot, status, free_slots, input ready);
  modport sink   (input valid, granted_slot, status, free_slots, output ready);
endinterface

>>> src/bsa_find_free.sv
module bsa_find_free
  import bsa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic [SLOTS-1:0] used_map,
  input  logic [8:0]       act_size,
  output logic [SLOTS-1:0] grant_onehot,
  output find_res_t        res
);

  logic [SLOTS-1:0] avail;

  // A slot is a candidate when it lies below the active size and is unused.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      avail[i] = !used_map[i] && (i < int'(act_size));
    end
  end

  // Isolate the lowest candidate bit.
  assign grant_onehot = avail & (~avail + {{(SLOTS-1){1'b0}}, 1'b1});

  // Encode the one-hot grant into a slot number.
  always_comb begin
    res.found = |avail;
    res.slot  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (grant_onehot[i]) begin
        res.slot = res.slot | 8'(i);
      end
    end
  end

endmodule

>>> src/bitmap_slot_allocator.sv
// Channel   Direction  Payload
// in_ch     sink       mode, slot_index
// out_ch    source     granted_slot, status, free_slots
// cfg       write      cfg_we, cfg_wdata (pool_size)
//
// One request per cycle while the result is not stalled.
// The lowest-free search and the bitmap update sit between the input register
// and the result register, so each request sees the bitmap left by the one
// before it. Reset clears the whole bitmap and sets the pool size to 256.
// A stalled result holds the input register, which then holds the input.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  bsa_req_if.sink     in_ch,
  bsa_rsp_if.source   out_ch
);

  localparam int SlotsCap = (SLOTS < 511) ? SLOTS : 511;

  // Active size is the pool size saturated at the slot count (at most 511).
  function automatic logic [8:0] clip_size(input logic [8:0] p);
    clip_size = (p > 9'(SlotsCap)) ? 9'(SlotsCap) : p;
  endfunction

  logic [8:0]       pool_size_r;
  logic [SLOTS-1:0] used_map_r, used_map_nxt;
  logic [8:0]       free_count_r, free_count_nxt;

  logic             s1_valid_r;
  logic             s1_mode_r;
  logic [7:0]       s1_slot_r;

  logic             out_valid_r;
  logic [7:0]       out_slot_r, out_slot_nxt;
  status_t          out_status_r, out_status_nxt;

  logic [8:0]       act_size;
  logic [SLOTS-1:0] grant_onehot;
  find_res_t        find_res;
  logic [SLOTS-1:0] free_sel;
  logic             slot_used;
  logic             out_adv;
  logic             s1_fire;

  assign act_size = clip_size(pool_size_r);
  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_adv;

  assign in_ch.ready = !s1_valid_r || out_adv;

  // Lowest free slot below the active size.
  bsa_find_free #(
    .SLOTS (SLOTS)
  ) u_find (
    .used_map     (used_map_r),
    .act_size     (act_size),
    .grant_onehot (grant_onehot),
    .res          (find_res)
  );

  // Decode the slot named by a free request.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_sel[i] = (i < 256) && (8'(i) == s1_slot_r);
    end
  end

  assign slot_used = |(used_map_r & free_sel);

  // Request processing: result fields and the bitmap and count update.
  always_comb begin
    used_map_nxt   = used_map_r;
    free_count_nxt = free_count_r;
    out_slot_nxt   = '0;
    out_status_nxt = ST_OK;
    if (s1_mode_r == MODE_ALLOC) begin
      if (find_res.found) begin
        used_map_nxt = used_map_r | grant_onehot;
        out_slot_nxt = find_res.slot;
        if (free_count_r != '0) begin
          free_count_nxt = free_count_r - 9'd1;
        end
      end else begin
        out_status_nxt = ST_FULL;
      end
    end else begin
      out_slot_nxt = s1_slot_r;
      if ({1'b0, s1_slot_r} >= act_size) begin
        out_status_nxt = ST_RANGE;
      end else if (!slot_used) begin
        out_status_nxt = ST_DOUBLE;
      end else begin
        used_map_nxt = used_map_r & ~free_sel;
        if (free_count_r < act_size) begin
          free_count_nxt = free_count_r + 9'd1;
        end
      end
    end
  end

  // Pool state; a pool size write starts a fresh pool.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r  <= POOL_SIZE_RST;
      used_map_r   <= '0;
      free_count_r <= clip_size(POOL_SIZE_RST);
    end else if (cfg_we) begin
      pool_size_r  <= cfg_wdata;
      used_map_r   <= '0;
      free_count_r <= clip_size(cfg_wdata);
    end else if (s1_fire) begin
      used_map_r   <= used_map_nxt;
      free_count_r <= free_count_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_slot_r <= in_ch.slot_index;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_slot_r   <= out_slot_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // The result carries the count as left by its own request.
  logic [8:0] out_free_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_free_r <= free_count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_slot = out_slot_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.free_slots   = out_free_r;

endmodule
